[rtl/tch_pkg.sv]
// Shared constants, types and step functions for the tilt-compensated heading pipeline.
`timescale 1ns / 1ps
package tch_pkg;
   localparam int CordicSteps  = 16;
   localparam int AtanEntries  = 24;
   localparam int CordicStages = (CordicSteps < AtanEntries) ? CordicSteps : AtanEntries;
   localparam int RootSteps    = 16;
   localparam int DivSteps     = 17;
   localparam int CosSteps     = 17;
   localparam int NormSteps    = 6;
   localparam int PathW        = 48;

   localparam logic [15:0] DeclReset   = 16'd1100;
   localparam logic [16:0] FullCircle  = 17'd36000;
   localparam logic [16:0] TwoCircles  = 17'd72000;
   localparam logic signed [31:0] QuarterTurn = 32'sd5898240;
   localparam logic signed [31:0] HalfTurn    = 32'sd11796480;
   localparam logic [32:0] UnitSquare  = 33'h1_0000_0000;

   localparam logic [1:0] CsrDeclAddr = 2'd0;

   typedef logic signed [31:0] atan_list_type [AtanEntries];
   localparam atan_list_type AtanDeg = '{
      32'sd2949120, 32'sd1740967, 32'sd919879, 32'sd466945, 32'sd234379, 32'sd117304,
      32'sd58666, 32'sd29335, 32'sd14668, 32'sd7334, 32'sd3667, 32'sd1833,
      32'sd917, 32'sd458, 32'sd229, 32'sd115, 32'sd57, 32'sd29,
      32'sd14, 32'sd7, 32'sd4, 32'sd2, 32'sd1, 32'sd0};

   typedef struct packed {
      logic signed [15:0] ax;
      logic signed [15:0] ay;
      logic signed [15:0] az;
      logic signed [15:0] mx;
      logic signed [15:0] my;
      logic signed [15:0] mz;
      logic signed [17:0] sp;
      logic signed [17:0] sr;
      logic               ok;
      logic               ypos;
   } meta_type;

   typedef struct packed {
      logic [18:0] rem;
      logic [16:0] root;
   } sqrt_step_type;

   typedef struct packed {
      logic [15:0] rem;
      logic        q;
   } div_step_type;

   function automatic sqrt_step_type sqrt_step(logic [18:0] rem, logic [16:0] root,
                                               logic [1:0] pair);
      logic [20:0] r;
      logic [20:0] t;
      sqrt_step_type res;
      r = {rem[18:0], pair};
      t = {2'b00, root, 2'b01};
      if (r >= t) begin
         res.rem  = 19'(r - t);
         res.root = {root[15:0], 1'b1};
      end else begin
         res.rem  = 19'(r);
         res.root = {root[15:0], 1'b0};
      end
      return res;
   endfunction

   function automatic div_step_type div_step(logic [15:0] rem, logic [15:0] den, logic b);
      logic [16:0] r;
      div_step_type res;
      r = {rem, b};
      if (r >= {1'b0, den}) begin
         res.rem = 16'(r - {1'b0, den});
         res.q   = 1'b1;
      end else begin
         res.rem = r[15:0];
         res.q   = 1'b0;
      end
      return res;
   endfunction
endpackage

[rtl/tch_if.sv]
// Request and response channel interfaces.
`timescale 1ns / 1ps
interface tch_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] accel_x;
   logic signed [15:0] accel_y;
   logic signed [15:0] accel_z;
   logic signed [15:0] field_x;
   logic signed [15:0] field_y;
   logic signed [15:0] field_z;
   modport source(output valid, accel_x, accel_y, accel_z, field_x, field_y, field_z,
                  input ready);
   modport sink(input valid, accel_x, accel_y, accel_z, field_x, field_y, field_z,
                output ready);
endinterface

interface tch_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] heading;
   logic        valid_res;
   modport source(output valid, heading, valid_res, input ready);
   modport sink(input valid, heading, valid_res, output ready);
endinterface

[rtl/tilt_compensated_heading.sv]
// Tilt-compensated compass heading: fully pipelined datapath with APB declination register.
`timescale 1ns / 1ps
// One beat enters per clock while the response side is not stalled. The pipeline depth is
// set by the bit-per-stage square roots, the bit-per-stage divider and the CORDIC
// vectoring stages. A stalled response freezes the whole pipeline; nothing is dropped.
// Zero-length vectors give valid_res = 0, heading 0.
module tilt_compensated_heading (
   input  logic        clock,
   input  logic        reset,
   tch_req_if.sink     req_ch,
   tch_rsp_if.source   rsp_ch,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   localparam int SSq    = 1;
   localparam int SNsq   = 2;
   localparam int SRoot0 = 3;
   localparam int SDiv0  = SRoot0 + tch_pkg::RootSteps;
   localparam int SSign  = SDiv0 + tch_pkg::DivSteps;
   localparam int SPSq   = SSign + 1;
   localparam int SRad   = SPSq + 1;
   localparam int SCos0  = SRad + 1;
   localparam int SMulA  = SCos0 + tch_pkg::CosSteps;
   localparam int SMulB  = SMulA + 1;
   localparam int SSum   = SMulB + 1;
   localparam int SPrep  = SSum + 1;
   localparam int SNorm0 = SPrep + 1;
   localparam int SRot   = SNorm0 + tch_pkg::NormSteps;
   localparam int SCor0  = SRot + 1;
   localparam int SFin1  = SCor0 + tch_pkg::CordicStages;
   localparam int SFin2  = SFin1 + 1;
   localparam int SFin3  = SFin2 + 1;
   localparam int Depth  = SFin3 + 1;
   localparam int W      = tch_pkg::PathW;

   logic             adv;
   logic [Depth-1:0] vld_ff;
   logic [15:0]      decl_ff;

   tch_pkg::meta_type meta_in [Depth];
   tch_pkg::meta_type meta_ff [Depth];

   // config port
   assign pready = 1'b1;
   assign prdata = (paddr == tch_pkg::CsrDeclAddr) ? {16'b0, decl_ff} : 32'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         decl_ff <= tch_pkg::DeclReset;
      end else if (psel && penable && pwrite && paddr == tch_pkg::CsrDeclAddr) begin
         decl_ff <= pwdata[15:0];
      end
   end

   // global advance
   assign adv          = !vld_ff[Depth-1] || rsp_ch.ready;
   assign req_ch.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[Depth-2:0], req_ch.valid};
      end
   end

   // stage 1..2: squared norm
   logic [31:0] sq_ff [3];
   logic [31:0] nsq_in;
   logic [31:0] nsq_ff;
   logic signed [31:0] sq_w [3];

   assign sq_w[0] = $signed(meta_ff[0].ax) * $signed(meta_ff[0].ax);
   assign sq_w[1] = $signed(meta_ff[0].ay) * $signed(meta_ff[0].ay);
   assign sq_w[2] = $signed(meta_ff[0].az) * $signed(meta_ff[0].az);
   assign nsq_in  = sq_ff[0] + sq_ff[1] + sq_ff[2];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= sq_w[i];
         end
         nsq_ff <= nsq_in;
      end
   end

   // norm square root
   logic [18:0] ra_rem_ff  [tch_pkg::RootSteps];
   logic [16:0] ra_root_ff [tch_pkg::RootSteps];
   logic [31:0] ra_rad_ff  [tch_pkg::RootSteps];

   for (genvar j = 0; j < tch_pkg::RootSteps; j++) begin : g_root
      logic [18:0] rem_prev;
      logic [16:0] root_prev;
      logic [31:0] rad_prev;
      tch_pkg::sqrt_step_type step_in;
      if (j == 0) begin : g_head
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = nsq_ff;
      end else begin : g_body
         assign rem_prev  = ra_rem_ff[j-1];
         assign root_prev = ra_root_ff[j-1];
         assign rad_prev  = ra_rad_ff[j-1];
      end
      assign step_in = tch_pkg::sqrt_step(rem_prev, root_prev, rad_prev[31:30]);
      always_ff @(posedge clock) begin
         if (adv) begin
            ra_rem_ff[j]  <= step_in.rem;
            ra_root_ff[j] <= step_in.root;
            ra_rad_ff[j]  <= {rad_prev[29:0], 2'b00};
         end
      end
   end

   // sine of pitch and roll: |a| * 2^16 / norm
   logic [15:0] dv_mag [2];
   logic [15:0] dv_rem_ff [2][tch_pkg::DivSteps];
   logic [16:0] dv_q_ff   [2][tch_pkg::DivSteps];
   logic [15:0] dv_den_ff [tch_pkg::DivSteps];

   assign dv_mag[0] = meta_ff[SDiv0-1].ax[15] ? 16'(-meta_ff[SDiv0-1].ax)
                                              : 16'(meta_ff[SDiv0-1].ax);
   assign dv_mag[1] = meta_ff[SDiv0-1].ay[15] ? 16'(-meta_ff[SDiv0-1].ay)
                                              : 16'(meta_ff[SDiv0-1].ay);

   for (genvar j = 0; j < tch_pkg::DivSteps; j++) begin : g_div
      logic [15:0] den_prev;
      if (j == 0) begin : g_head
         assign den_prev = ra_root_ff[tch_pkg::RootSteps-1][15:0];
      end else begin : g_body
         assign den_prev = dv_den_ff[j-1];
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            dv_den_ff[j] <= den_prev;
         end
      end
      for (genvar c = 0; c < 2; c++) begin : g_chan
         logic [15:0] rem_prev;
         logic [16:0] q_prev;
         logic        bit_in;
         tch_pkg::div_step_type step_in;
         if (j == 0) begin : g_head
            assign rem_prev = {1'b0, dv_mag[c][15:1]};
            assign q_prev   = '0;
            assign bit_in   = dv_mag[c][0];
         end else begin : g_body
            assign rem_prev = dv_rem_ff[c][j-1];
            assign q_prev   = dv_q_ff[c][j-1];
            assign bit_in   = 1'b0;
         end
         assign step_in = tch_pkg::div_step(rem_prev, den_prev, bit_in);
         always_ff @(posedge clock) begin
            if (adv) begin
               dv_rem_ff[c][j] <= step_in.rem;
               dv_q_ff[c][j]   <= {q_prev[15:0], step_in.q};
            end
         end
      end
   end

   logic signed [17:0] sp_in;
   logic signed [17:0] sr_in;
   assign sp_in = meta_ff[SSign-1].ax[15]
                ? -$signed({1'b0, dv_q_ff[0][tch_pkg::DivSteps-1]})
                :  $signed({1'b0, dv_q_ff[0][tch_pkg::DivSteps-1]});
   assign sr_in = meta_ff[SSign-1].ay[15]
                ? -$signed({1'b0, dv_q_ff[1][tch_pkg::DivSteps-1]})
                :  $signed({1'b0, dv_q_ff[1][tch_pkg::DivSteps-1]});

   // cosines
   logic signed [35:0] psq_w [2];
   logic [32:0] psq_ff [2];
   logic [33:0] rad_ff [2];

   assign psq_w[0] = meta_ff[SPSq-1].sp * meta_ff[SPSq-1].sp;
   assign psq_w[1] = meta_ff[SPSq-1].sr * meta_ff[SPSq-1].sr;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int c = 0; c < 2; c++) begin
            psq_ff[c] <= psq_w[c][32:0];
            rad_ff[c] <= (psq_ff[c] >= tch_pkg::UnitSquare)
                       ? 34'd0 : {1'b0, 33'(tch_pkg::UnitSquare - psq_ff[c])};
         end
      end
   end

   logic [18:0] cs_rem_ff  [2][tch_pkg::CosSteps];
   logic [16:0] cs_root_ff [2][tch_pkg::CosSteps];
   logic [33:0] cs_rad_ff  [2][tch_pkg::CosSteps];

   for (genvar c = 0; c < 2; c++) begin : g_cos
      for (genvar j = 0; j < tch_pkg::CosSteps; j++) begin : g_step
         logic [18:0] rem_prev;
         logic [16:0] root_prev;
         logic [33:0] rad_prev;
         tch_pkg::sqrt_step_type step_in;
         if (j == 0) begin : g_head
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign rad_prev  = rad_ff[c];
         end else begin : g_body
            assign rem_prev  = cs_rem_ff[c][j-1];
            assign root_prev = cs_root_ff[c][j-1];
            assign rad_prev  = cs_rad_ff[c][j-1];
         end
         assign step_in = tch_pkg::sqrt_step(rem_prev, root_prev, rad_prev[33:32]);
         always_ff @(posedge clock) begin
            if (adv) begin
               cs_rem_ff[c][j]  <= step_in.rem;
               cs_root_ff[c][j] <= step_in.root;
               cs_rad_ff[c][j]  <= {rad_prev[31:0], 2'b00};
            end
         end
      end
   end

   // tilt rotation
   logic signed [17:0] cp_s;
   logic signed [17:0] cr_s;
   logic signed [35:0] srsp_w, srcp_w, mxcp_w, mzsp_w, mycr_w;
   logic signed [35:0] srsp_ff, srcp_ff, mxcp_ff, mzsp_ff, mycr_ff;
   logic signed [51:0] t1_w, t2_w;
   logic signed [35:0] t1_ff, t2_ff, hx_ff, mycr2_ff;
   logic signed [35:0] hy_in;
   logic signed [35:0] hy_ff;
   logic signed [35:0] hx2_ff;

   assign cp_s   = $signed({1'b0, cs_root_ff[0][tch_pkg::CosSteps-1]});
   assign cr_s   = $signed({1'b0, cs_root_ff[1][tch_pkg::CosSteps-1]});
   assign srsp_w = meta_ff[SMulA-1].sr * meta_ff[SMulA-1].sp;
   assign srcp_w = meta_ff[SMulA-1].sr * cp_s;
   assign mxcp_w = meta_ff[SMulA-1].mx * cp_s;
   assign mzsp_w = meta_ff[SMulA-1].mz * meta_ff[SMulA-1].sp;
   assign mycr_w = meta_ff[SMulA-1].my * cr_s;
   assign t1_w   = meta_ff[SMulB-1].mx * srsp_ff;
   assign t2_w   = meta_ff[SMulB-1].mz * srcp_ff;
   assign hy_in  = t1_ff + mycr2_ff - t2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         srsp_ff  <= srsp_w;
         srcp_ff  <= srcp_w;
         mxcp_ff  <= mxcp_w;
         mzsp_ff  <= mzsp_w;
         mycr_ff  <= mycr_w;
         t1_ff    <= 36'(t1_w >>> 16);
         t2_ff    <= 36'(t2_w >>> 16);
         hx_ff    <= mxcp_ff + mzsp_ff;
         mycr2_ff <= mycr_ff;
         hy_ff    <= hy_in;
         hx2_ff   <= hx_ff;
      end
   end

   // prescale so the larger magnitude lands in [2^40, 2^41)
   logic [35:0] hx_abs, hy_abs;
   logic signed [W-1:0] px_ff, py_ff;
   logic [41:0] pm_ff;

   assign hx_abs = hx2_ff[35] ? 36'(-hx2_ff) : 36'(hx2_ff);
   assign hy_abs = hy_ff[35] ? 36'(-hy_ff) : 36'(hy_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         px_ff <= W'(hx2_ff) <<< 7;
         py_ff <= W'(hy_abs) << 7;
         pm_ff <= (hx_abs > hy_abs) ? {hx_abs, 6'b0} << 1 : {hy_abs, 6'b0} << 1;
      end
   end

   logic signed [W-1:0] nx_ff [tch_pkg::NormSteps];
   logic signed [W-1:0] ny_ff [tch_pkg::NormSteps];
   logic [41:0]         nm_ff [tch_pkg::NormSteps];

   for (genvar n = 0; n < tch_pkg::NormSteps; n++) begin : g_norm
      localparam int Sh = 32 >> n;
      logic signed [W-1:0] x_prev, y_prev;
      logic [41:0]         m_prev;
      logic                low;
      if (n == 0) begin : g_head
         assign x_prev = px_ff;
         assign y_prev = py_ff;
         assign m_prev = pm_ff;
      end else begin : g_body
         assign x_prev = nx_ff[n-1];
         assign y_prev = ny_ff[n-1];
         assign m_prev = nm_ff[n-1];
      end
      assign low = m_prev < (42'd1 << (41 - Sh));
      always_ff @(posedge clock) begin
         if (adv) begin
            nx_ff[n] <= low ? x_prev <<< Sh : x_prev;
            ny_ff[n] <= low ? y_prev <<< Sh : y_prev;
            nm_ff[n] <= low ? m_prev << Sh : m_prev;
         end
      end
   end

   // CORDIC vectoring
   logic signed [W-1:0] rx_ff, ry_ff;
   logic signed [31:0]  rz_ff;
   logic signed [W-1:0] nx_last, ny_last;

   assign nx_last = nx_ff[tch_pkg::NormSteps-1];
   assign ny_last = ny_ff[tch_pkg::NormSteps-1];

   always_ff @(posedge clock) begin
      if (adv) begin
         if (nx_last < 0) begin
            rx_ff <= ny_last;
            ry_ff <= -nx_last;
            rz_ff <= tch_pkg::QuarterTurn;
         end else begin
            rx_ff <= nx_last;
            ry_ff <= ny_last;
            rz_ff <= '0;
         end
      end
   end

   logic signed [W-1:0] cx_ff [tch_pkg::CordicStages];
   logic signed [W-1:0] cy_ff [tch_pkg::CordicStages];
   logic signed [31:0]  cz_ff [tch_pkg::CordicStages];

   for (genvar i = 0; i < tch_pkg::CordicStages; i++) begin : g_cordic
      logic signed [W-1:0] x_prev, y_prev;
      logic signed [31:0]  z_prev;
      if (i == 0) begin : g_head
         assign x_prev = rx_ff;
         assign y_prev = ry_ff;
         assign z_prev = rz_ff;
      end else begin : g_body
         assign x_prev = cx_ff[i-1];
         assign y_prev = cy_ff[i-1];
         assign z_prev = cz_ff[i-1];
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            if (y_prev > 0) begin
               cx_ff[i] <= x_prev + (y_prev >>> i);
               cy_ff[i] <= y_prev - (x_prev >>> i);
               cz_ff[i] <= z_prev + tch_pkg::AtanDeg[i];
            end else begin
               cx_ff[i] <= x_prev - (y_prev >>> i);
               cy_ff[i] <= y_prev + (x_prev >>> i);
               cz_ff[i] <= z_prev - tch_pkg::AtanDeg[i];
            end
         end
      end
   end

   // angle to hundredths, half-circle select, declination and wrap
   logic signed [31:0] zl;
   logic [31:0]        zc;
   logic [31:0]        zr;
   logic [15:0]        ax2_ff;
   logic [16:0]        head_ff;
   logic [16:0]        base;
   logic [15:0]        hd_ff;
   logic               vr_ff;

   assign zl   = cz_ff[tch_pkg::CordicStages-1];
   assign zc   = (zl < 0) ? 32'd0 : (zl > tch_pkg::HalfTurn) ? 32'(tch_pkg::HalfTurn) : 32'(zl);
   assign zr   = zc * 32'd100 + 32'd32768;
   assign base = meta_ff[SFin2-1].ypos ? {1'b0, ax2_ff} : tch_pkg::FullCircle - {1'b0, ax2_ff};

   always_ff @(posedge clock) begin
      if (adv) begin
         ax2_ff  <= zr[31:16];
         head_ff <= base + {1'b0, decl_ff};
         if (!meta_ff[SFin3-1].ok) begin
            hd_ff <= '0;
         end else if (head_ff > tch_pkg::TwoCircles) begin
            hd_ff <= 16'(head_ff - tch_pkg::TwoCircles);
         end else if (head_ff > tch_pkg::FullCircle) begin
            hd_ff <= 16'(head_ff - tch_pkg::FullCircle);
         end else begin
            hd_ff <= head_ff[15:0];
         end
         vr_ff <= meta_ff[SFin3-1].ok;
      end
   end

   assign rsp_ch.valid     = vld_ff[Depth-1];
   assign rsp_ch.heading   = hd_ff;
   assign rsp_ch.valid_res = vr_ff;

   // side-band carried with each beat
   always_comb begin
      meta_in[0]      = '0;
      meta_in[0].ax   = req_ch.accel_x;
      meta_in[0].ay   = req_ch.accel_y;
      meta_in[0].az   = req_ch.accel_z;
      meta_in[0].mx   = req_ch.field_x;
      meta_in[0].my   = req_ch.field_y;
      meta_in[0].mz   = req_ch.field_z;
   end

   for (genvar k = 1; k < Depth; k++) begin : g_meta
      always_comb begin
         meta_in[k] = meta_ff[k-1];
         if (k == SNsq) begin
            meta_in[k].ok = (nsq_in != '0);
         end
         if (k == SSign) begin
            meta_in[k].sp = sp_in;
            meta_in[k].sr = sr_in;
         end
         if (k == SSum) begin
            meta_in[k].ok   = meta_ff[k-1].ok && !(hx_ff == '0 && hy_in == '0);
            meta_in[k].ypos = (hy_in > 0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < Depth; k++) begin
            meta_ff[k] <= meta_in[k];
         end
      end
   end

   a_invalid_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.valid_res |-> rsp_ch.heading == '0)
      else $error("undefined heading not zero");
   a_heading_range : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> {1'b0, rsp_ch.heading} <= tch_pkg::FullCircle)
      else $error("heading out of range");
   a_stall_freeze : assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("pipeline moved during stall");
   a_norm_nonzero : assert property (@(posedge clock) disable iff (reset)
      vld_ff[SDiv0] && meta_ff[SDiv0].ok |-> dv_den_ff[0] != '0)
      else $error("zero divisor on a defined beat");
endmodule

[sim/tilt_compensated_heading_tb.sv]
// Self-checking testbench for the tilt-compensated heading pipeline.
`timescale 1ns / 1ps
module tilt_compensated_heading_tb;

   typedef struct {
      logic [15:0] heading;
      logic        valid_res;
   } heading_beat_type;

   class heading_board;
      heading_beat_type pending_q[$];
      logic [15:0]   decl = tch_pkg::DeclReset;
      int            errors = 0;

      function longint unsigned root_floor(longint unsigned v);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > v) b >>= 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v -= r + b;
               r = (r >> 1) + b;
            end else begin
               r >>= 1;
            end
            b >>= 2;
         end
         return r;
      endfunction

      function longint cos_q16(longint s);
         longint unsigned sq;
         sq = s * s;
         return (sq >= 64'h1_0000_0000) ? 0 : longint'(root_floor(64'h1_0000_0000 - sq));
      endfunction

      function void note_sample(longint ax, longint ay, longint az,
                                longint mx, longint my, longint mz);
         heading_beat_type e;
         longint norm, sr, cr, sp, cp, hx, hy, x, y, z, xs, ys, t, ang, head;
         longint unsigned nsq, mag;
         e.heading = 0;
         e.valid_res = 0;
         nsq = ax * ax + ay * ay + az * az;
         if (nsq != 0) begin
            norm = root_floor(nsq);
            sr = (ay * 65536) / norm;
            sp = (ax * 65536) / norm;
            cr = cos_q16(sr);
            cp = cos_q16(sp);
            hx = mx * cp + mz * sp;
            hy = ((mx * sr * sp) >>> 16) + my * cr - ((mz * sr * cp) >>> 16);
            if (hx != 0 || hy != 0) begin
               x = hx;
               y = (hy < 0) ? -hy : hy;
               mag = (x < 0) ? -x : x;
               if (y > longint'(mag)) mag = y;
               while (mag < (64'd1 << 40)) begin
                  x *= 2;
                  y *= 2;
                  mag <<= 1;
               end
               z = 0;
               if (x < 0) begin
                  t = x;
                  x = y;
                  y = -t;
                  z = longint'(tch_pkg::QuarterTurn);
               end
               for (int i = 0; i < tch_pkg::CordicStages; i++) begin
                  xs = x >>> i;
                  ys = y >>> i;
                  if (y > 0) begin
                     x = x + ys;
                     y = y - xs;
                     z += longint'(tch_pkg::AtanDeg[i]);
                  end else begin
                     x = x - ys;
                     y = y + xs;
                     z -= longint'(tch_pkg::AtanDeg[i]);
                  end
               end
               if (z < 0) z = 0;
               if (z > longint'(tch_pkg::HalfTurn)) z = longint'(tch_pkg::HalfTurn);
               ang = (z * 100 + 32768) >>> 16;
               head = (hy > 0) ? ang : 36000 - ang;
               head += decl;
               while (head > 36000) head -= 36000;
               e.heading = head[15:0];
               e.valid_res = 1'b1;
            end
         end
         pending_q.push_back(e);
      endfunction

      function void check_result(logic [15:0] heading, logic valid_res);
         heading_beat_type e;
         if (pending_q.size() == 0) begin
            $display("%0t: unexpected beat heading=%0d valid_res=%0d",
                     $time, heading, valid_res);
            errors++;
            return;
         end
         e = pending_q.pop_front();
         if (heading !== e.heading) begin
            $display("%0t: heading expected %0d actual %0d", $time, e.heading, heading);
            errors++;
         end
         if (valid_res !== e.valid_res) begin
            $display("%0t: valid_res expected %0d actual %0d", $time, e.valid_res,
                     valid_res);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        psel, penable, pwrite;
   logic [1:0]  paddr;
   logic [31:0] pwdata, prdata;
   logic        pready;
   bit          quiet = 0;
   bit          hold_rsp = 0;
   heading_board board;

   tch_req_if req_ch();
   tch_rsp_if rsp_ch();

   tilt_compensated_heading u_dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            board.note_sample(req_ch.accel_x, req_ch.accel_y, req_ch.accel_z,
                              req_ch.field_x, req_ch.field_y, req_ch.field_z);
         if (rsp_ch.valid && rsp_ch.ready)
            board.check_result(rsp_ch.heading, rsp_ch.valid_res);
      end
   end

   // response side back-pressure
   initial begin
      int n;
      rsp_ch.ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            rsp_ch.ready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_rsp = 0;
         end else if (quiet || $urandom_range(0, 2) != 0) begin
            rsp_ch.ready <= 1'b1;
            n = $urandom_range(1, 20);
            repeat (n) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b0;
            n = $urandom_range(1, 15);
            repeat (n) @(posedge clock);
         end
      end
   end

   task automatic send_sample(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                              logic [15:0] mx, logic [15:0] my, logic [15:0] mz);
      req_ch.valid   <= 1'b1;
      req_ch.accel_x <= ax;
      req_ch.accel_y <= ay;
      req_ch.accel_z <= az;
      req_ch.field_x <= mx;
      req_ch.field_y <= my;
      req_ch.field_z <= mz;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic req_gap();
      int n;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, 15);
         req_ch.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send_random();
      logic [15:0] ax, ay, az;
      ax = 16'($urandom);
      ay = 16'($urandom);
      az = 16'($urandom);
      case ($urandom_range(0, 9))
         0: {ax, ay, az} = '0;
         1: begin
            ax = 16'($urandom_range(0, 15) - 8);
            ay = 16'($urandom_range(0, 15) - 8);
         end
         default: ;
      endcase
      if ($urandom_range(0, 19) == 0)
         send_sample(ax, ay, az, 16'd0, 16'd0, 16'd0);
      else
         send_sample(ax, ay, az, 16'($urandom), 16'($urandom), 16'($urandom));
      req_gap();
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (board.pending_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_decl(logic [15:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= tch_pkg::CsrDeclAddr;
      pwdata  <= {16'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      board.decl = value;
   endtask

   initial begin
      logic [15:0] decl_set [6] = '{16'd0, 16'd36000, 16'd35999, 16'd65535, 16'd18000,
                                    16'd1100};
      board = new;
      reset         <= 1'b1;
      req_ch.valid  <= 1'b0;
      {req_ch.accel_x, req_ch.accel_y, req_ch.accel_z} <= '0;
      {req_ch.field_x, req_ch.field_y, req_ch.field_z} <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset declination, directed corners
      send_sample(0, 0, 0, 100, 200, 300);
      send_sample(0, 0, 1000, 0, 0, 0);
      send_sample(0, 0, 1000, 100, 0, 0);
      send_sample(0, 0, 1000, -100, 0, 0);
      send_sample(0, 0, 1000, 0, 100, 0);
      send_sample(0, 0, 1000, 0, -100, 0);
      send_sample(0, 0, 1000, -100, 5, 0);
      send_sample(0, 0, 1000, -100, -5, 0);
      send_sample(16'h7FFF, 0, 0, 1, 2, 3);
      send_sample(16'h8000, 0, 0, 1, 2, 3);
      send_sample(0, 16'h7FFF, 0, 1, 2, 3);
      send_sample(0, 16'h8000, 0, 1, 2, 3);
      send_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_sample(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
      send_sample(1, 0, 0, 0, 0, 16'h7FFF);
      send_sample(0, 0, 16'hFFFF, 16'h7FFF, 16'h8000, 0);
      send_sample(0, 0, 1, 1, 1, 1);
      drain();

      for (int p = 0; p < 6; p++) begin
         write_decl(decl_set[p]);
         if (p == 1) hold_rsp = 1;
         if (p == 5) quiet = 1;
         repeat (150) send_random();
         drain();
      end

      if (board.errors == 0 && board.pending_q.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #3_000_000;
      $display("RESULT: ERROR");
      $finish;
   end
endmodule
